// ----- src/chsp_pkg.sv -----
// Shared types, codes and helpers for the convex hull support point block.
`default_nettype none
package chsp_pkg;

    localparam int CHSP_MAX_VERTICES = 256;
    localparam int MAT_W             = 22;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_SUPPORT = 2'd1;
    localparam logic [1:0] OP_SPEED   = 2'd2;

    localparam logic [2:0] CFG_POINT_COUNT  = 3'd0;
    localparam logic [2:0] CFG_COM_X        = 3'd1;
    localparam logic [2:0] CFG_COM_Y        = 3'd2;
    localparam logic [2:0] CFG_COM_Z        = 3'd3;
    localparam logic [2:0] CFG_SUPPORT_BIAS = 3'd4;

    localparam logic RK_SUPPORT = 1'b0;
    localparam logic RK_SPEED   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN
    } chsp_state_t;

    typedef enum logic [1:0] {
        AUX_IDLE,
        AUX_SQRT,
        AUX_DIV,
        AUX_DONE
    } chsp_aux_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/convex_hull_support_point.sv -----
// Top level: vertex store, per-vertex query pipeline, square root and bias dividers.
`default_nettype none
// A write item (opcode 0) stores one vertex; busy stays low. A support
// or speed query holds busy high while it streams the N valid vertices out of the
// single-port vertex memory, one per cycle, through a five-stage multiply/compare
// pipeline: a setup state, the read walk over the N vertices and a drain state.
// A support query also runs a 32-step square root and three 64-step dividers for the
// bias offset in parallel with the walk; the drain lasts until both are done. Each
// result is shown for exactly one cycle with result_valid high, which is not held.
module convex_hull_support_point #(
    parameter int MAX_VERTICES = chsp_pkg::CHSP_MAX_VERTICES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [7:0]         vertex_index,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic signed [31:0] dir_z,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [17:0] quat_w,
    input  wire logic signed [17:0] quat_x,
    input  wire logic signed [17:0] quat_y,
    input  wire logic signed [17:0] quat_z,
    output logic                    result_valid,
    output logic                    result_kind,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      point_z,
    output logic [30:0]             max_speed,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import chsp_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    // configuration
    logic [8:0]         point_count_reg;
    logic signed [31:0] com_reg [3];
    logic signed [31:0] bias_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 9'd1;
            com_reg[0]      <= '0;
            com_reg[1]      <= '0;
            com_reg[2]      <= '0;
            bias_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POINT_COUNT:  point_count_reg <= cfg_data[8:0];
                CFG_COM_X:        com_reg[0]      <= cfg_data;
                CFG_COM_Y:        com_reg[1]      <= cfg_data;
                CFG_COM_Z:        com_reg[2]      <= cfg_data;
                CFG_SUPPORT_BIAS: bias_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    chsp_state_t state_reg, state_next;
    chsp_aux_t   aux_reg, aux_next;
    logic        accept, rd_en, finish, pipe_busy;
    logic [AW-1:0] addr_reg, last_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;

    assign accept    = start && !busy;
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (opcode == OP_SUPPORT || opcode == OP_SPEED))
                    state_next = ST_SETUP;
            ST_SETUP: state_next = ST_WALK;
            ST_WALK:  if (addr_reg == last_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (!pipe_busy && aux_reg == AUX_DONE) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        rd_en  = (state_reg == ST_WALK);
        finish = (state_reg == ST_DRAIN) && !pipe_busy && (aux_reg == AUX_DONE);
    end

    // latched query operands
    logic [1:0]         op_reg;
    logic signed [31:0] d_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [17:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic [CW-1:0] pc_ext, n_eff;
    always_comb
    begin
        pc_ext = CW'(point_count_reg);
        if (pc_ext == '0)
            n_eff = CW'(1);
        else if (pc_ext > CW'(MAX_VERTICES))
            n_eff = CW'(MAX_VERTICES);
        else
            n_eff = pc_ext;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            d_reg[0] <= dir_x;
            d_reg[1] <= dir_y;
            d_reg[2] <= dir_z;
            v_reg[0] <= vec_x;
            v_reg[1] <= vec_y;
            v_reg[2] <= vec_z;
            qw_reg   <= quat_w;
            qx_reg   <= quat_x;
            qy_reg   <= quat_y;
            qz_reg   <= quat_z;
            last_reg <= AW'(n_eff - CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0; v5_reg <= 1'b0;
            f1_reg <= 1'b0; f2_reg <= 1'b0; f3_reg <= 1'b0; f4_reg <= 1'b0; f5_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP)
                addr_reg <= '0;
            else if (rd_en)
                addr_reg <= addr_reg + AW'(1);
            v1_reg <= rd_en;
            f1_reg <= rd_en && (addr_reg == '0);
            v2_reg <= v1_reg; f2_reg <= f1_reg;
            v3_reg <= v2_reg; f3_reg <= f2_reg;
            v4_reg <= v3_reg; f4_reg <= f3_reg;
            v5_reg <= v4_reg; f5_reg <= f4_reg;
        end
    end

    // vertex memory
    logic signed [31:0] mem_x [MAX_VERTICES];
    logic signed [31:0] mem_y [MAX_VERTICES];
    logic signed [31:0] mem_z [MAX_VERTICES];
    logic signed [31:0] rd_reg [3];
    logic [CW-1:0]      idx_ext;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    assign idx_ext = CW'(vertex_index);
    assign wr_addr = AW'(vertex_index);
    assign wr_en   = accept && (opcode == OP_WRITE) && (idx_ext < CW'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= dir_x;
            mem_y[wr_addr] <= dir_y;
            mem_z[wr_addr] <= dir_z;
        end
        if (rd_en)
        begin
            rd_reg[0] <= mem_x[addr_reg];
            rd_reg[1] <= mem_y[addr_reg];
            rd_reg[2] <= mem_z[addr_reg];
        end
    end

    // rotation matrix, squared length and bias numerators
    logic signed [MAT_W-1:0] m_reg [3][3];
    logic signed [35:0] qxx, qyy, qzz, qxy, qxz, qyz, qwx, qwy, qwz;
    logic signed [39:0] t00, t01, t02, t10, t11, t12, t20, t21, t22;
    logic signed [39:0] one40;
    logic signed [63:0] dd [3];
    logic signed [63:0] num [3];
    logic [63:0]        s2;

    always_comb
    begin
        qxx = qx_reg * qx_reg;
        qyy = qy_reg * qy_reg;
        qzz = qz_reg * qz_reg;
        qxy = qx_reg * qy_reg;
        qxz = qx_reg * qz_reg;
        qyz = qy_reg * qz_reg;
        qwx = qw_reg * qx_reg;
        qwy = qw_reg * qy_reg;
        qwz = qw_reg * qz_reg;
        one40 = 40'sd1 <<< 32;
        t00 = one40 - ((40'(qyy) + 40'(qzz)) <<< 1);
        t01 = (40'(qxy) - 40'(qwz)) <<< 1;
        t02 = (40'(qxz) + 40'(qwy)) <<< 1;
        t10 = (40'(qxy) + 40'(qwz)) <<< 1;
        t11 = one40 - ((40'(qxx) + 40'(qzz)) <<< 1);
        t12 = (40'(qyz) - 40'(qwx)) <<< 1;
        t20 = (40'(qxz) - 40'(qwy)) <<< 1;
        t21 = (40'(qyz) + 40'(qwx)) <<< 1;
        t22 = one40 - ((40'(qxx) + 40'(qyy)) <<< 1);
        for (int k = 0; k < 3; k++)
        begin
            dd[k]  = 64'(d_reg[k]) * 64'(d_reg[k]);
            num[k] = 64'(d_reg[k]) * 64'(bias_reg);
        end
        s2 = dd[0] + dd[1] + dd[2];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            m_reg[0][0] <= MAT_W'(t00 >>> 16);
            m_reg[0][1] <= MAT_W'(t01 >>> 16);
            m_reg[0][2] <= MAT_W'(t02 >>> 16);
            m_reg[1][0] <= MAT_W'(t10 >>> 16);
            m_reg[1][1] <= MAT_W'(t11 >>> 16);
            m_reg[1][2] <= MAT_W'(t12 >>> 16);
            m_reg[2][0] <= MAT_W'(t20 >>> 16);
            m_reg[2][1] <= MAT_W'(t21 >>> 16);
            m_reg[2][2] <= MAT_W'(t22 >>> 16);
        end
    end

    // square root then three restoring dividers
    logic [63:0] sq_s_reg, sq_r_reg, sq_bit_reg, sq_t;
    logic [5:0]  aux_cnt_reg, aux_cnt_next;
    logic [63:0] dv_num_reg [3];
    logic [31:0] dv_rem_reg [3];
    logic        dv_neg_reg [3];
    logic [32:0] dv_sh [3];
    logic        dv_ge [3];
    logic [31:0] len;

    assign sq_t = sq_r_reg + sq_bit_reg;
    assign len  = sq_r_reg[31:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv_sh[k] = {dv_rem_reg[k], dv_num_reg[k][63]};
            dv_ge[k] = (dv_sh[k] >= {1'b0, len});
        end
    end

    always_comb
    begin
        aux_next     = aux_reg;
        aux_cnt_next = aux_cnt_reg;
        if (state_reg == ST_SETUP)
        begin
            aux_next     = (op_reg == OP_SUPPORT) ? AUX_SQRT : AUX_DONE;
            aux_cnt_next = '0;
        end
        else
        begin
            case (aux_reg)
                AUX_SQRT:
                begin
                    if (aux_cnt_reg == SQRT_LAST)
                    begin
                        aux_next     = AUX_DIV;
                        aux_cnt_next = '0;
                    end
                    else
                        aux_cnt_next = aux_cnt_reg + 6'd1;
                end
                AUX_DIV:
                begin
                    if (aux_cnt_reg == DIV_LAST)
                        aux_next = AUX_DONE;
                    else
                        aux_cnt_next = aux_cnt_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_reg     <= AUX_IDLE;
            aux_cnt_reg <= '0;
        end
        else
        begin
            aux_reg     <= aux_next;
            aux_cnt_reg <= aux_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
        begin
            sq_s_reg   <= s2;
            sq_r_reg   <= '0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
            for (int k = 0; k < 3; k++)
            begin
                dv_neg_reg[k] <= num[k][63];
                dv_num_reg[k] <= num[k][63] ? 64'(-num[k]) : 64'(num[k]);
                dv_rem_reg[k] <= '0;
            end
        end
        else if (aux_reg == AUX_SQRT)
        begin
            if (sq_s_reg >= sq_t)
            begin
                sq_s_reg <= sq_s_reg - sq_t;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        else if (aux_reg == AUX_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[k] <= dv_ge[k] ? 32'(dv_sh[k] - {1'b0, len}) : dv_sh[k][31:0];
                dv_num_reg[k] <= {dv_num_reg[k][62:0], dv_ge[k]};
            end
        end
    end

    // per-vertex pipeline
    logic signed [53:0] pm_reg [3][3];
    logic signed [32:0] r_reg [3];
    logic signed [55:0] row [3];
    logic signed [31:0] pb_reg [3], pc_reg [3], pd_reg [3];
    logic signed [64:0] cp_reg [6];
    logic signed [61:0] dp_reg [3];
    logic signed [31:0] lv_reg [3];
    logic signed [63:0] dist_reg;
    logic signed [47:0] sp_reg [3];
    logic signed [49:0] sp_sum;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            row[k] = 56'(pm_reg[k][0]) + 56'(pm_reg[k][1]) + 56'(pm_reg[k][2]);
        sp_sum = 50'(sp_reg[0]) + 50'(sp_reg[1]) + 50'(sp_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
                pm_reg[k][j] <= 54'(m_reg[k][j]) * 54'(rd_reg[j]);
            r_reg[k]  <= 33'(rd_reg[k]) - 33'(com_reg[k]);
            pb_reg[k] <= sat32(66'(row[k] >>> 16) + 66'(v_reg[k]));
            dp_reg[k] <= 62'((64'(d_reg[k]) * 64'(pb_reg[k])) >>> 2);
            pc_reg[k] <= pb_reg[k];
            pd_reg[k] <= pc_reg[k];
            sp_reg[k] <= 48'((64'(d_reg[k]) * 64'(lv_reg[k])) >>> 16);
        end
        cp_reg[0] <= 65'(v_reg[1]) * 65'(r_reg[2]);
        cp_reg[1] <= 65'(v_reg[2]) * 65'(r_reg[1]);
        cp_reg[2] <= 65'(v_reg[2]) * 65'(r_reg[0]);
        cp_reg[3] <= 65'(v_reg[0]) * 65'(r_reg[2]);
        cp_reg[4] <= 65'(v_reg[0]) * 65'(r_reg[1]);
        cp_reg[5] <= 65'(v_reg[1]) * 65'(r_reg[0]);
        lv_reg[0] <= sat32(66'(cp_reg[0] >>> 16) - 66'(cp_reg[1] >>> 16));
        lv_reg[1] <= sat32(66'(cp_reg[2] >>> 16) - 66'(cp_reg[3] >>> 16));
        lv_reg[2] <= sat32(66'(cp_reg[4] >>> 16) - 66'(cp_reg[5] >>> 16));
        dist_reg  <= 64'(dp_reg[0]) + 64'(dp_reg[1]) + 64'(dp_reg[2]);
    end

    // running best
    logic signed [63:0] bestd_reg;
    logic signed [31:0] best_p_reg [3];
    logic signed [49:0] best_speed_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP)
            best_speed_reg <= '0;
        else if (v5_reg && op_reg == OP_SPEED && sp_sum > best_speed_reg)
            best_speed_reg <= sp_sum;
        // keep the earlier vertex on a tie
        if (v5_reg && op_reg == OP_SUPPORT && (f5_reg || dist_reg > bestd_reg))
        begin
            bestd_reg <= dist_reg;
            for (int k = 0; k < 3; k++)
                best_p_reg[k] <= pd_reg[k];
        end
    end

    // result
    logic signed [63:0] off [3];
    logic signed [31:0] pt [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (len == '0)
                off[k] = '0;
            else if (dv_neg_reg[k])
                off[k] = -$signed(dv_num_reg[k]);
            else
                off[k] = $signed(dv_num_reg[k]);
            pt[k] = sat32(66'(best_p_reg[k]) + 66'(off[k]));
        end
    end

    logic               result_valid_reg, result_kind_reg;
    logic signed [31:0] point_x_reg, point_y_reg, point_z_reg;
    logic [30:0]        max_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= finish;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (op_reg == OP_SUPPORT)
            begin
                result_kind_reg <= RK_SUPPORT;
                point_x_reg     <= pt[0];
                point_y_reg     <= pt[1];
                point_z_reg     <= pt[2];
                max_speed_reg   <= '0;
            end
            else
            begin
                result_kind_reg <= RK_SPEED;
                point_x_reg     <= '0;
                point_y_reg     <= '0;
                point_z_reg     <= '0;
                max_speed_reg   <= (best_speed_reg > 50'sd2147483647) ? 31'h7fffffff
                                                                       : best_speed_reg[30:0];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign point_z      = point_z_reg;
    assign max_speed    = max_speed_reg;

endmodule
`default_nettype wire
